// ===== rtl/cau_pkg.sv =====
// shared types and codes for the complex arithmetic unit
// used by complex_arithmetic_unit_core; no other dependencies
`default_nettype none

package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MULT = 3'd2,
        OP_DIV  = 3'd3,
        OP_MOD  = 3'd4,
        OP_DIST = 3'd5
    } cau_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DIV_SAT  = 2'd2
    } cau_status_t;

    localparam logic [31:0] INT32_MAX_C = 32'h7fff_ffff;

    // side information that travels beside the divider and root pipelines
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] re;
        logic [31:0] im;
        logic        neg_re;
        logic        neg_im;
        logic        dz;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/cau_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
// standalone; no package needed
`default_nettype none

module cau_div_pipe #(
    parameter int NW  = 43,
    parameter int DVW = 33
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [NW-1:0]  num,
    input  wire logic [DVW-1:0] dvs,
    output logic      [NW-1:0]  quo
);

    logic [NW-1:0]  num_reg [0:NW];
    logic [DVW-1:0] dvs_reg [0:NW];
    logic [DVW-1:0] rem_reg [0:NW];
    logic [NW-1:0]  quo_reg [0:NW];

    always_comb begin
        num_reg[0] = num;
        dvs_reg[0] = dvs;
        rem_reg[0] = '0;
        quo_reg[0] = '0;
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DVW:0] trial;
        logic         ge;
        logic [DVW:0] diff;
        assign trial = {rem_reg[k], num_reg[k][NW-1]};
        assign ge    = trial >= {1'b0, dvs_reg[k]};
        assign diff  = trial - {1'b0, dvs_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k+1] <= {num_reg[k][NW-2:0], 1'b0};
                dvs_reg[k+1] <= dvs_reg[k];
                rem_reg[k+1] <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
                quo_reg[k+1] <= {quo_reg[k][NW-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[NW];

endmodule

`default_nettype wire

// ===== rtl/cau_sqrt_pipe.sv =====
// pipelined integer square root, two radicand bits per stage
// padded to LAT stages so it lines up with the divider; no package needed
`default_nettype none

module cau_sqrt_pipe #(
    parameter int RW  = 17,
    parameter int LAT = 43
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [2*RW-1:0] rad,
    output logic      [RW-1:0]   root
);

    logic [2*RW-1:0] rad_reg  [0:LAT];
    logic [RW+1:0]   rem_reg  [0:LAT];
    logic [RW-1:0]   root_reg [0:LAT];

    always_comb begin
        rad_reg[0]  = rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    for (genvar k = 0; k < LAT; k++) begin : g_stage
        if (k < RW) begin : g_step
            logic [RW+1:0] cur;
            logic [RW+1:0] trial;
            logic          ge;
            assign cur   = {rem_reg[k][RW-1:0], rad_reg[k][2*RW-1 -: 2]};
            assign trial = {root_reg[k], 2'b01};
            assign ge    = cur >= trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k+1]  <= {rad_reg[k][2*RW-3:0], 2'b00};
                    rem_reg[k+1]  <= ge ? cur - trial : cur;
                    root_reg[k+1] <= {root_reg[k][RW-2:0], ge};
                end
            end
        end else begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k+1]  <= rad_reg[k];
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
            end
        end
    end

    assign root = root_reg[LAT];

endmodule

`default_nettype wire

// ===== rtl/complex_arithmetic_unit_core.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide, modulus and distance on
// complex Q(IN_WIDTH-FRAC_BITS).FRAC_BITS operands, result in signed 32-bit with
// FRAC_BITS fraction bits. Fully pipelined: one request per clock unless stalled, and every
// request gives one result. The divider works one quotient bit per stage. The whole pipeline
// stalls while m_tvalid is high and m_tready is low.
// Depends on cau_pkg, cau_div_pipe and cau_sqrt_pipe.
`default_nettype none

module complex_arithmetic_unit_core
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int IN_WIDTH  = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
    input  wire logic [((4*IN_WIDTH+7)/8)*8-1:0]     s_tdata,
    // req_type
    input  wire logic [2:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // res_re, res_im from the lowest bit up
    output logic [63:0]                              m_tdata,
    // status
    output logic [1:0]                               m_tuser
);

    localparam int PW   = 2 * IN_WIDTH;
    localparam int SATW = 2 * IN_WIDTH + 4;
    localparam int SQW  = 2 * IN_WIDTH + 2;
    localparam int RW   = IN_WIDTH + 1;
    localparam int NW   = 2 * IN_WIDTH + FRAC_BITS + 3;
    localparam int DVW  = 2 * IN_WIDTH + 1;
    localparam logic signed [SATW-1:0] RND = SATW'(1 << FRAC_BITS) >> 1;

    function automatic logic [32:0] sat32(input logic signed [SATW-1:0] x);
        if (x > SATW'(signed'({1'b0, INT32_MAX_C})))
            return {1'b1, INT32_MAX_C};
        else if (x < -SATW'(signed'({1'b0, INT32_MAX_C})) - SATW'(1))
            return {1'b1, ~INT32_MAX_C};
        else
            return {1'b0, x[31:0]};
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 0: capture
    logic                       v0_reg;
    cau_op_t                    op0_reg;
    logic signed [IN_WIDTH-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op0_reg <= cau_op_t'(s_tuser);
            ar_reg  <= $signed(s_tdata[0*IN_WIDTH +: IN_WIDTH]);
            ai_reg  <= $signed(s_tdata[1*IN_WIDTH +: IN_WIDTH]);
            br_reg  <= $signed(s_tdata[2*IN_WIDTH +: IN_WIDTH]);
            bi_reg  <= $signed(s_tdata[3*IN_WIDTH +: IN_WIDTH]);
        end
    end

    // stage 1: products and add/sub
    logic signed [IN_WIDTH:0]   x_next, y_next;
    logic signed [SQW-1:0]      sx_full, sy_full;
    logic [32:0]                sum_re_s, sum_im_s;

    always_comb begin
        case (op0_reg)
            OP_MOD: begin
                x_next = (IN_WIDTH+1)'(ar_reg);
                y_next = (IN_WIDTH+1)'(ai_reg);
            end
            OP_DIST: begin
                x_next = (IN_WIDTH+1)'(ar_reg) - (IN_WIDTH+1)'(br_reg);
                y_next = (IN_WIDTH+1)'(ai_reg) - (IN_WIDTH+1)'(bi_reg);
            end
            default: begin
                x_next = (IN_WIDTH+1)'(br_reg);
                y_next = (IN_WIDTH+1)'(bi_reg);
            end
        endcase
        sx_full = SQW'(x_next) * SQW'(x_next);
        sy_full = SQW'(y_next) * SQW'(y_next);
        if (op0_reg == OP_SUB) begin
            sum_re_s = sat32(SATW'(ar_reg) - SATW'(br_reg));
            sum_im_s = sat32(SATW'(ai_reg) - SATW'(bi_reg));
        end else begin
            sum_re_s = sat32(SATW'(ar_reg) + SATW'(br_reg));
            sum_im_s = sat32(SATW'(ai_reg) + SATW'(bi_reg));
        end
    end

    logic                  v1_reg;
    cau_op_t               op1_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [SQW-2:0]        sx_reg, sy_reg;
    logic [31:0]           sum_re_reg, sum_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg    <= op0_reg;
            p_rr_reg   <= ar_reg * br_reg;
            p_ii_reg   <= ai_reg * bi_reg;
            p_ri_reg   <= ar_reg * bi_reg;
            p_ir_reg   <= ai_reg * br_reg;
            sx_reg     <= sx_full[SQW-2:0];
            sy_reg     <= sy_full[SQW-2:0];
            sum_re_reg <= sum_re_s[31:0];
            sum_im_reg <= sum_im_s[31:0];
        end
    end

    // stage 2: combine products, set up divider and root
    logic signed [SATW-1:0] mre_w, mim_w;
    logic [32:0]            mre_s, mim_s;
    logic signed [PW:0]     num_re_w, num_im_w;
    logic [PW:0]            mag_re_w, mag_im_w;
    logic [SQW-1:0]         sq_w;
    side_t                  side_next;

    always_comb begin
        mre_w    = (SATW'(p_rr_reg) - SATW'(p_ii_reg) + RND) >>> FRAC_BITS;
        mim_w    = (SATW'(p_ri_reg) + SATW'(p_ir_reg) + RND) >>> FRAC_BITS;
        mre_s    = sat32(mre_w);
        mim_s    = sat32(mim_w);
        num_re_w = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
        num_im_w = (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
        mag_re_w = num_re_w[PW] ? -num_re_w : num_re_w;
        mag_im_w = num_im_w[PW] ? -num_im_w : num_im_w;
        sq_w     = SQW'(sx_reg) + SQW'(sy_reg);

        side_next        = '0;
        side_next.op     = op1_reg;
        side_next.neg_re = num_re_w[PW];
        side_next.neg_im = num_im_w[PW];
        side_next.dz     = (sq_w == '0);
        case (op1_reg)
            OP_ADD, OP_SUB: begin
                side_next.re = sum_re_reg;
                side_next.im = sum_im_reg;
            end
            OP_MULT: begin
                side_next.re = mre_s[31:0];
                side_next.im = mim_s[31:0];
            end
            default: ;
        endcase
    end

    logic             v2_reg;
    side_t            side2_reg;
    logic [NW-1:0]    dnum_re_reg, dnum_im_reg;
    logic [DVW-1:0]   dvs_reg;
    logic [SQW-1:0]   rad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    // (mag << (frac+1)) + den over (den << 1) rounds half away from zero
    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg   <= side_next;
            dnum_re_reg <= (NW'(mag_re_w) << (FRAC_BITS + 1)) + NW'(sq_w[PW-1:0]);
            dnum_im_reg <= (NW'(mag_im_w) << (FRAC_BITS + 1)) + NW'(sq_w[PW-1:0]);
            dvs_reg     <= {sq_w[PW-1:0], 1'b0};
            rad_reg     <= sq_w;
        end
    end

    // long stages
    logic [NW-1:0] q_re, q_im;
    logic [RW-1:0] root;

    cau_div_pipe #(.NW(NW), .DVW(DVW)) u_div_re (
        .aclk (aclk),
        .en   (en),
        .num  (dnum_re_reg),
        .dvs  (dvs_reg),
        .quo  (q_re)
    );

    cau_div_pipe #(.NW(NW), .DVW(DVW)) u_div_im (
        .aclk (aclk),
        .en   (en),
        .num  (dnum_im_reg),
        .dvs  (dvs_reg),
        .quo  (q_im)
    );

    cau_sqrt_pipe #(.RW(RW), .LAT(NW)) u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    side_t side_dly_reg [0:NW-1];
    logic  v_dly_reg    [0:NW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NW; i++) v_dly_reg[i] <= 1'b0;
        end else if (en) begin
            v_dly_reg[0] <= v2_reg;
            for (int i = 1; i < NW; i++) v_dly_reg[i] <= v_dly_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_dly_reg[0] <= side2_reg;
            for (int i = 1; i < NW; i++) side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // final stage: division saturation and result select
    side_t       sd;
    logic [31:0] dre_w, dim_w;
    logic        clip_re, clip_im;
    logic [31:0] res_re_next, res_im_next;
    cau_status_t status_next;

    always_comb begin
        sd = side_dly_reg[NW-1];
        if (sd.neg_re) begin
            clip_re = q_re > NW'({1'b0, ~INT32_MAX_C});
            dre_w   = clip_re ? ~INT32_MAX_C : (~q_re[31:0]) + 32'd1;
        end else begin
            clip_re = q_re > NW'(INT32_MAX_C);
            dre_w   = clip_re ? INT32_MAX_C : q_re[31:0];
        end
        if (sd.neg_im) begin
            clip_im = q_im > NW'({1'b0, ~INT32_MAX_C});
            dim_w   = clip_im ? ~INT32_MAX_C : (~q_im[31:0]) + 32'd1;
        end else begin
            clip_im = q_im > NW'(INT32_MAX_C);
            dim_w   = clip_im ? INT32_MAX_C : q_im[31:0];
        end

        res_re_next = sd.re;
        res_im_next = sd.im;
        status_next = ST_OK;
        case (sd.op)
            OP_DIV: begin
                if (sd.dz) begin
                    res_re_next = '0;
                    res_im_next = '0;
                    status_next = ST_DIV_ZERO;
                end else begin
                    res_re_next = dre_w;
                    res_im_next = dim_w;
                    if (clip_re || clip_im) status_next = ST_DIV_SAT;
                end
            end
            OP_MOD, OP_DIST: begin
                res_re_next = (33'(root) > 33'(INT32_MAX_C)) ? INT32_MAX_C : 32'(root);
                res_im_next = '0;
            end
            default: ;
        endcase
    end

    logic [63:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v_dly_reg[NW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {res_im_next, res_re_next};
            m_tuser_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
